// ----- rtl/maf_pkg.sv -----
// shared types, constants and helper functions of the moving average filter
// no dependencies; maf_div and moving_average_filter import this package
`default_nettype none

package maf_pkg;

	localparam int MAX_KERNEL   = 32;
	localparam int MAX_RECORD   = 65536;
	localparam int KERNEL_MIN   = 3;
	localparam int KERNEL_RESET = 3;

	localparam int SAMPLE_W = 16;
	localparam int KER_W    = 6;
	localparam int ADDR_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int PTR_W    = ADDR_W + 1;
	localparam int SUM_W    = SAMPLE_W + ADDR_W;

	localparam int COUNT_CAP = (MAX_RECORD > MAX_KERNEL) ? MAX_RECORD : MAX_KERNEL + 1;
	localparam int COUNT_W   = $clog2(COUNT_CAP + 1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       error;
		logic                       last_res;
	} out_item_t;

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [KER_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic                       busy;
		logic                       done;
		logic signed [SAMPLE_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_HEAD_RD,
		ST_HEAD_LD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MEAN_LD,
		ST_TAIL_RD,
		ST_TAIL_LD,
		ST_ERR_LD
	} state_t;

	function automatic logic [KER_W-1:0] clamp_kernel(input logic [KER_W-1:0] k);
		if (int'(k) < KERNEL_MIN) begin
			return KER_W'(KERNEL_MIN);
		end else if (int'(k) > MAX_KERNEL) begin
			return KER_W'(MAX_KERNEL);
		end else begin
			return k;
		end
	endfunction

	// raw samples passed through ahead of the first mean
	function automatic logic [KER_W-1:0] head_len(input logic [KER_W-1:0] k);
		if (k[0]) begin
			return k >> 1;
		end else begin
			return (k >> 1) - KER_W'(1);
		end
	endfunction

	// raw samples passed through after the last mean
	function automatic logic [KER_W-1:0] tail_len(input logic [KER_W-1:0] k);
		return k - KER_W'(1) - head_len(k);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/maf_ram.sv -----
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
`default_nettype none

module maf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                  wdata,
	input  logic                              re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/maf_div.sv -----
// bit-serial signed divider of the window sum by the record kernel, one bit a cycle
// depends on maf_pkg
`default_nettype none

module maf_div import maf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(SUM_W);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [KER_W-1:0] rem_q;
	logic [KER_W-1:0] divisor_q;
	logic [SUM_W-1:0] quo_q;

	logic [SUM_W-1:0] mag;
	logic [KER_W:0]   trial;
	logic [KER_W:0]   diff;
	logic             fits;
	logic [SUM_W-1:0] quo_s;

	assign mag   = req.dividend[SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};
	assign quo_s = neg_q ? (~quo_q + 1'b1) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(SUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q     <= req.dividend[SUM_W-1];
			rem_q     <= '0;
			divisor_q <= req.divisor;
			quo_q     <= mag;
		end else if (busy_q) begin
			rem_q <= fits ? diff[KER_W-1:0] : trial[KER_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_s[SAMPLE_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/moving_average_filter.sv -----
// top level of the moving average filter: record sequencer, window ram, divider and output register
// depends on maf_pkg, maf_ram and maf_div
`default_nettype none

// Boxcar filter over records of signed 16-bit samples. The window of the latest
// kernel_size samples sits in a MAX_KERNEL-deep ram next to a running sum; each
// accepted sample costs one ram read of the sample leaving the window and one write.
// A sample that yields a mean waits for the bit-serial divider, which truncates the
// sum toward zero. Raw head samples on fill and raw tail samples after the last mean
// each take one ram read and one output load. A record shorter than the kernel gives
// one error beat. kernel_size is latched at the first sample of a record, values
// outside 3..MAX_KERNEL are clamped. The result sits in an output register, so the
// next sample is taken while a result waits. No clearing pass.
module moving_average_filter import maf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [KER_W-1:0] cfg_data,
	input  logic             src_valid,
	output logic             src_ready,
	input  in_item_t         src_data,
	output logic             res_valid,
	input  logic             res_ready,
	output out_item_t        res_data
);

	state_t state_q, state_d;

	logic [KER_W-1:0]          kernel_q;
	logic [KER_W-1:0]          rec_k_q;
	logic [ADDR_W-1:0]         wp_q;
	logic [COUNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [KER_W-1:0]          idx_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                      last_q;
	logic                      out_valid_q;
	out_item_t                 out_q;

	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic                wr_en;
	logic [SAMPLE_W-1:0] ram_rdata;

	logic      load;
	out_item_t out_d;
	logic      upd;
	logic      end_rec;
	logic      idx_clr;
	logic      idx_inc;
	logic      slot_free;
	logic      div_start;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [KER_W-1:0]        hlen;
	logic [KER_W-1:0]        tlen;
	logic [PTR_W-1:0]        old_sum;
	logic [ADDR_W-1:0]       old_addr;
	logic [PTR_W-1:0]        tail_sum;
	logic [ADDR_W-1:0]       tail_addr;
	logic [ADDR_W-1:0]       wp_inc;
	logic [COUNT_W-1:0]      count_inc;
	logic [COUNT_W-1:0]      k_ext;
	logic signed [SAMPLE_W-1:0] old_val;
	logic signed [SUM_W-1:0] sum_next;

	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	assign hlen  = head_len(rec_k_q);
	assign tlen  = tail_len(rec_k_q);
	assign k_ext = COUNT_W'(rec_k_q);

	// slot of the sample leaving the window, ring modulo MAX_KERNEL
	assign old_sum  = PTR_W'(wp_q) + PTR_W'(MAX_KERNEL) - PTR_W'(rec_k_q);
	assign old_addr = (old_sum >= PTR_W'(MAX_KERNEL)) ?
		ADDR_W'(old_sum - PTR_W'(MAX_KERNEL)) : ADDR_W'(old_sum);

	// wp_q already points past the last sample here
	assign tail_sum  = PTR_W'(wp_q) + PTR_W'(MAX_KERNEL) - PTR_W'(tlen) + PTR_W'(idx_q);
	assign tail_addr = (tail_sum >= PTR_W'(MAX_KERNEL)) ?
		ADDR_W'(tail_sum - PTR_W'(MAX_KERNEL)) : ADDR_W'(tail_sum);

	assign wp_inc    = (wp_q == ADDR_W'(MAX_KERNEL - 1)) ? '0 : wp_q + 1'b1;
	assign count_inc = (count_q < COUNT_W'(COUNT_CAP)) ? count_q + 1'b1 : count_q;
	assign old_val   = (count_q >= k_ext) ? $signed(ram_rdata) : '0;
	assign sum_next  = sum_q + SUM_W'(sample_q) - SUM_W'(old_val);

	assign div_req = '{start: div_start, dividend: sum_q, divisor: rec_k_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		src_ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		load      = 1'b0;
		out_d     = '0;
		upd       = 1'b0;
		end_rec   = 1'b0;
		idx_clr   = 1'b0;
		idx_inc   = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				src_ready = 1'b1;
				if (src_valid) begin
					rd_en   = 1'b1;
					rd_addr = old_addr;
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				wr_en   = 1'b1;
				upd     = 1'b1;
				idx_clr = 1'b1;
				if (count_inc < k_ext) begin
					state_d = last_q ? ST_ERR_LD : ST_IDLE;
				end else if (count_inc == k_ext) begin
					state_d = ST_HEAD_RD;
				end else begin
					state_d = ST_DIV_GO;
				end
			end
			ST_HEAD_RD: begin
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(idx_q);
				state_d = ST_HEAD_LD;
			end
			ST_HEAD_LD: begin
				if (slot_free) begin
					load        = 1'b1;
					out_d.value = ram_rdata;
					if (idx_q == hlen - 1'b1) begin
						state_d = ST_DIV_GO;
					end else begin
						idx_inc = 1'b1;
						state_d = ST_HEAD_RD;
					end
				end
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				idx_clr   = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_MEAN_LD;
				end
			end
			ST_MEAN_LD: begin
				if (slot_free) begin
					load        = 1'b1;
					out_d.value = div_rsp.quotient;
					state_d     = last_q ? ST_TAIL_RD : ST_IDLE;
				end
			end
			ST_TAIL_RD: begin
				rd_en   = 1'b1;
				rd_addr = tail_addr;
				state_d = ST_TAIL_LD;
			end
			ST_TAIL_LD: begin
				if (slot_free) begin
					load        = 1'b1;
					out_d.value = ram_rdata;
					if (idx_q == tlen - 1'b1) begin
						out_d.last_res = 1'b1;
						end_rec        = 1'b1;
						state_d        = ST_IDLE;
					end else begin
						idx_inc = 1'b1;
						state_d = ST_TAIL_RD;
					end
				end
			end
			ST_ERR_LD: begin
				if (slot_free) begin
					load           = 1'b1;
					out_d.error    = 1'b1;
					out_d.last_res = 1'b1;
					end_rec        = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q    <= KER_W'(KERNEL_RESET);
			rec_k_q     <= '0;
			wp_q        <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				kernel_q <= cfg_data;
			end
			// kernel is fixed for the whole record
			if (src_valid && src_ready && count_q == '0) begin
				rec_k_q <= clamp_kernel(kernel_q);
			end
			if (end_rec) begin
				wp_q    <= '0;
				count_q <= '0;
				sum_q   <= '0;
			end else if (upd) begin
				wp_q    <= wp_inc;
				count_q <= count_inc;
				sum_q   <= sum_next;
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			sample_q <= src_data.sample;
			last_q   <= src_data.last;
		end
		if (load) begin
			out_q <= out_d;
		end
	end

	maf_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_KERNEL)
	) u_window (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wp_q),
		.wdata(sample_q),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	maf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.error |-> res_data.last_res && res_data.value == '0)
		else $error("error beat must carry zero value and end the record");

	assert property (@(posedge clk) disable iff (!arst_n)
		int'(wp_q) < MAX_KERNEL)
		else $error("write pointer beyond window ram");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> int'(rec_k_q) >= KERNEL_MIN && int'(rec_k_q) <= MAX_KERNEL)
		else $error("record kernel out of range during a record");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

endmodule

`default_nettype wire
